>>> rtl/sma_pkg.sv
package sma_pkg;

    // Sizing
    localparam int WINDOW_MAX  = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int CFG_W       = 7;
    localparam int SLOT_W      = $clog2(WINDOW_MAX);
    localparam int LEN_W       = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W       = SAMPLE_BITS + SLOT_W;
    localparam int CNT_W       = $clog2(SUM_W);

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_DIV_LOAD,
        S_DIV,
        S_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic update;
        logic div_load;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic produce;
        logic div_done;
        logic out_busy;
    } t_dp_sts;

endpackage

>>> rtl/sma_in_if.sv
interface sma_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [sma_pkg::SAMPLE_BITS-1:0] sample;
    logic                                  start_of_set;

    modport source (output valid, output sample, output start_of_set, input ready);
    modport sink   (input valid, input sample, input start_of_set, output ready);
endinterface

>>> rtl/sma_out_if.sv
interface sma_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [sma_pkg::SAMPLE_BITS-1:0] average;

    modport source (output valid, output average, input ready);
    modport sink   (input valid, input average, output ready);
endinterface

>>> rtl/sma_ram.sv
module sma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/sma_ctrl.sv
module sma_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  sma_pkg::t_dp_sts i_sts,
    output sma_pkg::t_dp_cmd o_cmd
);
    import sma_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = i_sts.produce ? S_DIV_LOAD : S_IDLE;
            end
            S_DIV_LOAD: begin
                o_cmd.div_load = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/sma_dp.sv
module sma_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [sma_pkg::CFG_W-1:0]             i_cfg_wdata,
    input  sma_pkg::t_dp_cmd                      i_cmd,
    output sma_pkg::t_dp_sts                      o_sts,
    input  logic signed [sma_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic                                  i_start_of_set,
    output logic signed [sma_pkg::SAMPLE_BITS-1:0] o_average,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready
);
    import sma_pkg::*;

    logic [CFG_W-1:0]              r_wlen;
    logic [LEN_W-1:0]              r_fill;
    logic signed [SUM_W-1:0]       r_sum;
    logic [SLOT_W-1:0]             r_slot;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic                          r_start;
    logic                          r_neg;
    logic [LEN_W-1:0]              r_rem;
    logic [SUM_W-1:0]              r_quo;
    logic [CNT_W-1:0]              r_cnt;
    logic signed [SAMPLE_BITS-1:0] r_out;
    logic                          r_out_valid;

    logic [LEN_W-1:0]              len_eff;
    logic [SLOT_W-1:0]             old_addr;
    logic signed [SAMPLE_BITS-1:0] old_x;
    logic [LEN_W-1:0]              fill0;
    logic signed [SUM_W-1:0]       sum0;
    logic [LEN_W-1:0]              n_fill;
    logic signed [SUM_W-1:0]       n_sum;
    logic signed [SUM_W-1:0]       sum1;
    logic                          produce;
    logic [LEN_W:0]                rem_sh;
    logic                          q_bit;
    logic [LEN_W-1:0]              n_rem;
    logic [SAMPLE_BITS-1:0]        q_mag;

    // Window length saturated at the delay line depth
    assign len_eff  = (r_wlen > CFG_W'(WINDOW_MAX)) ? LEN_W'(WINDOW_MAX)
                                                      : LEN_W'(r_wlen);
    // Slot of the sample leaving the window (same slot when the window is full depth)
    assign old_addr = r_slot - len_eff[SLOT_W-1:0];

    // Delay line
    sma_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (i_cmd.update),
        .i_waddr (r_slot),
        .i_wdata (r_x),
        .i_re    (i_cmd.capture),
        .i_raddr (old_addr),
        .o_rdata (old_x)
    );

    // Running sum and fill count update
    always_comb begin
        fill0   = r_start ? '0 : r_fill;
        sum0    = r_start ? '0 : r_sum;
        n_fill  = '0;
        n_sum   = '0;
        sum1    = sum0;
        produce = 1'b0;
        if (len_eff != '0) begin
            if (fill0 >= len_eff) begin
                sum1   = sum0 - SUM_W'(old_x);
                n_fill = len_eff;
            end else begin
                n_fill = fill0 + LEN_W'(1);
            end
            n_sum   = sum1 + SUM_W'(r_x);
            produce = (n_fill >= len_eff);
        end
    end

    // One quotient bit per step, restoring
    assign rem_sh = {r_rem, r_quo[SUM_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, len_eff});
    always_comb begin
        if (q_bit) begin
            n_rem = LEN_W'(rem_sh - {1'b0, len_eff});
        end else begin
            n_rem = rem_sh[LEN_W-1:0];
        end
    end

    assign q_mag = r_quo[SAMPLE_BITS-1:0];

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen      <= CFG_W'(1);
            r_fill      <= '0;
            r_sum       <= '0;
            r_slot      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_wlen <= i_cfg_wdata;
                r_fill <= '0;
                r_sum  <= '0;
            end else if (i_cmd.update) begin
                r_fill <= n_fill;
                r_sum  <= n_sum;
            end
            if (i_cmd.update) begin
                r_slot <= r_slot + SLOT_W'(1);
            end
            if (i_cmd.div_load) begin
                r_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_x     <= i_sample;
            r_start <= i_start_of_set;
        end
        if (i_cmd.div_load) begin
            r_neg <= r_sum[SUM_W-1];
            r_quo <= r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[SUM_W-2:0], q_bit};
            r_rem <= n_rem;
        end
        if (i_cmd.out_load) begin
            r_out <= r_neg ? SAMPLE_BITS'(-q_mag) : SAMPLE_BITS'(q_mag);
        end
    end

    assign o_sts.produce  = produce;
    assign o_sts.div_done = (r_cnt == CNT_W'(SUM_W - 1));
    assign o_sts.out_busy = r_out_valid && !i_out_ready;
    assign o_average      = r_out;
    assign o_out_valid    = r_out_valid;

endmodule

>>> rtl/sliding_window_average_core.sv
// Moving average over a signed Q8.8 stream, iterative divider, one item at a time.
// Sequence: an item that gives no result passes IDLE and UPDATE; one that gives a result
//   goes on through DIV_LOAD, the 22-step restoring divider (one quotient bit per cycle)
//   and EMIT, which waits out any output stall; the output register lets the next item
//   be taken while a result waits.
// Reset (synchronous, active low): window length 1, sum, fill and slot cleared; delay line kept.
module sliding_window_average_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [sma_pkg::CFG_W-1:0]   i_cfg_wdata,
    sma_in_if.sink                      i_in,
    sma_out_if.source                   o_out
);
    import sma_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;

    sma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sma_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_sample       (i_in.sample),
        .i_start_of_set (i_in.start_of_set),
        .o_average      (o_out.average),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready)
    );

    assign i_in.ready = in_ready;

`ifndef SYNTHESIS
    // Input is never ready in the cycle after an item is accepted
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken on consecutive cycles");

    // A waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> !(o_out.valid && !o_out.ready))
        else $error("result register loaded while occupied");

    // Datapath commands are exclusive
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command");
`endif

endmodule
